// File: rtl/core/c_subset_token_scanner_defines.svh
// Assertion macros shared by the scanner checker
`ifndef C_SUBSET_TOKEN_SCANNER_DEFINES_SVH
`define C_SUBSET_TOKEN_SCANNER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define CTSS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define CTSS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/ctss_pkg.sv
// Shared types, token kinds and character helpers of the token scanner
package ctss_pkg;

	localparam logic [5:0] K_ERR     = 6'd0;
	localparam logic [5:0] K_END     = 6'd1;
	localparam logic [5:0] K_IDENT   = 6'd2;
	localparam logic [5:0] K_INT     = 6'd3;
	localparam logic [5:0] K_LONG    = 6'd4;
	localparam logic [5:0] K_FLOAT   = 6'd5;
	localparam logic [5:0] K_CHAR    = 6'd6;
	localparam logic [5:0] K_KW0     = 6'd7;
	localparam logic [5:0] K_PLUS    = 6'd17;
	localparam logic [5:0] K_MINUS   = 6'd18;
	localparam logic [5:0] K_STAR    = 6'd19;
	localparam logic [5:0] K_SLASH   = 6'd20;
	localparam logic [5:0] K_PERCENT = 6'd21;
	localparam logic [5:0] K_ASSIGN  = 6'd22;
	localparam logic [5:0] K_EQ      = 6'd23;
	localparam logic [5:0] K_NE      = 6'd24;
	localparam logic [5:0] K_GT      = 6'd25;
	localparam logic [5:0] K_GE      = 6'd26;
	localparam logic [5:0] K_LT      = 6'd27;
	localparam logic [5:0] K_LE      = 6'd28;
	localparam logic [5:0] K_AND     = 6'd29;
	localparam logic [5:0] K_OR      = 6'd30;
	localparam logic [5:0] K_LPAREN  = 6'd31;
	localparam logic [5:0] K_RPAREN  = 6'd32;
	localparam logic [5:0] K_LBRACK  = 6'd33;
	localparam logic [5:0] K_RBRACK  = 6'd34;
	localparam logic [5:0] K_LBRACE  = 6'd35;
	localparam logic [5:0] K_RBRACE  = 6'd36;
	localparam logic [5:0] K_SEMI    = 6'd37;
	localparam logic [5:0] K_COMMA   = 6'd38;
	localparam logic [5:0] K_PREP    = 6'd39;
	localparam logic [5:0] K_COMMENT = 6'd40;

	localparam int NUM_KW = 10;
	// keyword text, last character in the low byte
	localparam logic [63:0] KW_WORD [NUM_KW] = '{
		64'("int"), 64'("float"), 64'("char"), 64'("if"), 64'("else"),
		64'("while"), 64'("for"), 64'("return"), 64'("break"), 64'("continue")
	};
	localparam logic [3:0] KW_LEN [NUM_KW] = '{
		4'd3, 4'd5, 4'd4, 4'd2, 4'd4, 4'd5, 4'd3, 4'd6, 4'd5, 4'd8
	};

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	typedef struct packed {
		logic [5:0]  kind;
		logic [7:0]  len;
		logic [15:0] line;
		logic        last;
	} tok_t;

	// up to two tokens produced by one byte
	typedef struct packed {
		logic [1:0] cnt;
		tok_t       tok0;
		tok_t       tok1;
	} push_t;

	function automatic logic is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_alpha(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_hex(logic [7:0] c);
		return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic logic [5:0] single_kind(logic [7:0] c);
		logic [5:0] k;
		k = K_ERR;
		case (c)
			"+": k = K_PLUS;
			"-": k = K_MINUS;
			"*": k = K_STAR;
			"%": k = K_PERCENT;
			"(": k = K_LPAREN;
			")": k = K_RPAREN;
			"[": k = K_LBRACK;
			"]": k = K_RBRACK;
			"{": k = K_LBRACE;
			"}": k = K_RBRACE;
			";": k = K_SEMI;
			",": k = K_COMMA;
			default: k = K_ERR;
		endcase
		return k;
	endfunction

	function automatic logic [5:0] oper_single(logic [7:0] f);
		logic [5:0] k;
		k = K_ERR;
		if (f == "=") k = K_ASSIGN;
		else if (f == "<") k = K_LT;
		else if (f == ">") k = K_GT;
		return k;
	endfunction

endpackage

// File: rtl/core/ctss_scan.sv
// Front end: per-byte scanner state machine that classifies bytes into tokens
module ctss_scan #(
	parameter int LINE_COUNT_BITS = 16,
	parameter int LENGTH_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  logic [7:0]         source_byte,
	input  logic               end_of_input,
	output ctss_pkg::push_t    push
);
	import ctss_pkg::*;

	typedef enum logic [3:0] {
		M_IDLE, M_IDENT, M_NUM, M_DOT, M_SLASH, M_LINE, M_BLOCK, M_BSTAR,
		M_PREP, M_CH_OPEN, M_CH_ESC, M_CH_BODY, M_OPER
	} mode_t;

	localparam logic [1:0] NF_INT  = 2'd0;
	localparam logic [1:0] NF_HEX  = 2'd1;
	localparam logic [1:0] NF_FRAC = 2'd2;

	mode_t                      mode_q, mode_n;
	logic [LENGTH_BITS-1:0]     len_q, len_n, len_g;
	logic [LINE_COUNT_BITS-1:0] line_q, line_n, line_g;
	logic [NUM_KW-1:0]          mask_q, mask_n, mask_hit, mask_start;
	logic [1:0]                 nf_q, nf_n;
	logic [7:0]                 first_q, first_n;

	logic                   a_v, b_v, used, pair;
	logic [5:0]             a_k, b_k, ident_k, pair_k;
	logic [LENGTH_BITS-1:0] a_l, b_l;
	logic [7:0]             c;
	logic [15:0]            line_out;

	function automatic logic [7:0] sat_len(logic [LENGTH_BITS-1:0] v);
		logic [7:0] r;
		if (32'(v) > 32'd255) r = 8'hFF;
		else r = 8'(v);
		return r;
	endfunction

	// keyword candidates whose character at position pos equals byte ch
	function automatic logic [NUM_KW-1:0] kw_hits(logic [LENGTH_BITS-1:0] pos,
			logic [7:0] ch);
		logic [NUM_KW-1:0] h;
		int base;
		for (int i = 0; i < NUM_KW; i++) begin
			h[i] = 1'b0;
			if (32'(pos) < 32'(KW_LEN[i])) begin
				base = 8 * (int'(KW_LEN[i]) - 1 - int'(pos));
				h[i] = (KW_WORD[i][base +: 8] == ch);
			end
		end
		return h;
	endfunction

	assign c = source_byte;
	assign len_g = (len_q == '1) ? len_q : len_q + 1'b1;
	assign line_g = (line_q == '1) ? line_q : line_q + 1'b1;
	assign mask_hit = mask_q & kw_hits(len_q, c);
	assign mask_start = kw_hits('0, c);
	assign line_out = (32'(line_q) > 32'd65535) ? 16'hFFFF : 16'(line_q);

	always_comb begin
		ident_k = K_IDENT;
		for (int i = NUM_KW - 1; i >= 0; i--) begin
			if (mask_q[i] && 32'(KW_LEN[i]) == 32'(len_q)) ident_k = K_KW0 + 6'(i);
		end
	end

	always_comb begin
		pair = 1'b0;
		pair_k = K_ERR;
		if (c == "=") begin
			case (first_q)
				"=": begin pair = 1'b1; pair_k = K_EQ; end
				"!": begin pair = 1'b1; pair_k = K_NE; end
				"<": begin pair = 1'b1; pair_k = K_LE; end
				">": begin pair = 1'b1; pair_k = K_GE; end
				default: ;
			endcase
		end
		if (first_q == "&" && c == "&") begin pair = 1'b1; pair_k = K_AND; end
		if (first_q == "|" && c == "|") begin pair = 1'b1; pair_k = K_OR; end
	end

	always_comb begin
		mode_n = mode_q;
		len_n = len_q;
		line_n = line_q;
		mask_n = mask_q;
		nf_n = nf_q;
		first_n = first_q;
		a_v = 1'b0;
		a_k = K_ERR;
		a_l = len_q;
		b_v = 1'b0;
		b_k = K_ERR;
		b_l = LENGTH_BITS'(1);
		used = 1'b0;
		if (end_of_input) begin
			a_v = (mode_q != M_IDLE);
			unique case (mode_q)
				M_IDENT: a_k = ident_k;
				M_NUM:   a_k = (nf_q == NF_FRAC) ? K_FLOAT : K_INT;
				M_SLASH: a_k = K_SLASH;
				M_LINE:  a_k = K_COMMENT;
				M_PREP:  a_k = K_PREP;
				M_OPER:  a_k = oper_single(first_q);
				default: a_k = K_ERR;
			endcase
			b_v = 1'b1;
			b_k = K_END;
			b_l = '0;
			mode_n = M_IDLE;
		end else begin
			unique case (mode_q)
				M_IDLE: ;
				M_IDENT: begin
					if (is_alpha(c) || is_digit(c) || c == "_") begin
						used = 1'b1; mask_n = mask_hit; len_n = len_g;
					end else begin
						a_v = 1'b1; a_k = ident_k;
					end
				end
				M_NUM: begin
					if (nf_q == NF_FRAC) begin
						if (is_digit(c)) begin
							used = 1'b1; len_n = len_g;
						end else if (c == "F" || c == "f") begin
							used = 1'b1; len_n = len_g; a_v = 1'b1; a_k = K_FLOAT;
							a_l = len_g; mode_n = M_IDLE;
						end else begin
							a_v = 1'b1; a_k = K_FLOAT;
						end
					end else if ((nf_q == NF_HEX) ? is_hex(c) : is_digit(c)) begin
						used = 1'b1; len_n = len_g;
					end else if (nf_q != NF_HEX && (c == "x" || c == "X")
							&& len_q == LENGTH_BITS'(1) && first_q == "0") begin
						used = 1'b1; len_n = len_g; nf_n = NF_HEX;
					end else if (c == ".") begin
						used = 1'b1; len_n = len_g; nf_n = NF_FRAC;
					end else if (c == "F" || c == "f") begin
						used = 1'b1; len_n = len_g; a_v = 1'b1; a_k = K_FLOAT;
						a_l = len_g; mode_n = M_IDLE;
					end else if (c == "L" || c == "l") begin
						used = 1'b1; len_n = len_g; a_v = 1'b1; a_k = K_LONG;
						a_l = len_g; mode_n = M_IDLE;
					end else begin
						a_v = 1'b1; a_k = K_INT;
					end
				end
				M_DOT: begin
					if (is_digit(c)) begin
						used = 1'b1; len_n = len_g; mode_n = M_NUM; nf_n = NF_FRAC;
					end else begin
						a_v = 1'b1; a_k = K_ERR;
					end
				end
				M_SLASH: begin
					if (c == "/") begin
						used = 1'b1; len_n = len_g; mode_n = M_LINE;
					end else if (c == "*") begin
						used = 1'b1; len_n = len_g; mode_n = M_BLOCK;
					end else begin
						a_v = 1'b1; a_k = K_SLASH;
					end
				end
				M_LINE, M_PREP: begin
					if (c != 8'h0A) begin
						used = 1'b1; len_n = len_g;
					end else begin
						a_v = 1'b1; a_k = (mode_q == M_LINE) ? K_COMMENT : K_PREP;
					end
				end
				M_BLOCK, M_BSTAR: begin
					used = 1'b1;
					len_n = len_g;
					if (c == "/" && mode_q == M_BSTAR) begin
						a_v = 1'b1; a_k = K_COMMENT; a_l = len_g; mode_n = M_IDLE;
					end else begin
						if (c == 8'h0A) line_n = line_g;
						mode_n = (c == "*") ? M_BSTAR : M_BLOCK;
					end
				end
				M_CH_OPEN: begin
					used = 1'b1;
					len_n = len_g;
					if (c == "\\") mode_n = M_CH_ESC;
					else if (c == "'" || c == 8'h0A) begin
						a_v = 1'b1; a_k = K_ERR; a_l = len_g; mode_n = M_IDLE;
					end else mode_n = M_CH_BODY;
				end
				M_CH_ESC: begin
					used = 1'b1;
					len_n = len_g;
					if (c == "n" || c == "t" || c == "r" || c == "0") mode_n = M_CH_BODY;
					else begin
						a_v = 1'b1; a_k = K_ERR; a_l = len_g; mode_n = M_IDLE;
					end
				end
				M_CH_BODY: begin
					used = 1'b1; len_n = len_g; a_v = 1'b1;
					a_k = (c == "'") ? K_CHAR : K_ERR; a_l = len_g; mode_n = M_IDLE;
				end
				M_OPER: begin
					if (pair) begin
						used = 1'b1; len_n = len_g; a_v = 1'b1; a_k = pair_k;
						a_l = len_g; mode_n = M_IDLE;
					end else begin
						a_v = 1'b1; a_k = oper_single(first_q);
					end
				end
				default: ;
			endcase
			if (!used) begin
				mode_n = M_IDLE;
				if (c == 8'h0A) line_n = line_g;
				else if (c != " " && c != 8'h09 && c != 8'h0D) begin
					len_n = LENGTH_BITS'(1);
					first_n = c;
					nf_n = NF_INT;
					if (is_alpha(c) || c == "_") begin
						mask_n = mask_start; mode_n = M_IDENT;
					end else if (is_digit(c)) mode_n = M_NUM;
					else begin
						case (c)
							".": mode_n = M_DOT;
							"/": mode_n = M_SLASH;
							"#": mode_n = M_PREP;
							"'": mode_n = M_CH_OPEN;
							"=", "!", "<", ">", "&", "|": mode_n = M_OPER;
							default: begin
								b_v = 1'b1; b_k = single_kind(c);
							end
						endcase
					end
				end
			end
		end
	end

	// pack the step's tokens, first one in tok0
	always_comb begin
		push.cnt = {1'b0, a_v} + {1'b0, b_v};
		push.tok0.kind = a_v ? a_k : b_k;
		push.tok0.len = sat_len(a_v ? a_l : b_l);
		push.tok0.line = line_out;
		push.tok0.last = !(a_v && b_v);
		push.tok1.kind = b_k;
		push.tok1.len = sat_len(b_l);
		push.tok1.line = line_out;
		push.tok1.last = 1'b1;
		if (!take) push.cnt = 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			len_q <= '0;
			line_q <= LINE_COUNT_BITS'(1);
			mask_q <= '1;
			nf_q <= NF_INT;
			first_q <= '0;
		end else if (take) begin
			mode_q <= mode_n;
			len_q <= len_n;
			line_q <= line_n;
			mask_q <= mask_n;
			nf_q <= nf_n;
			first_q <= first_n;
		end
	end

endmodule

// File: rtl/core/ctss_fifo.sv
// Token queue between scanner and output: two writes, one read per cycle
module ctss_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  ctss_pkg::push_t push,
	output logic            room,
	output logic            nonempty,
	output ctss_pkg::tok_t  head,
	input  logic            pop
);
	import ctss_pkg::*;

	tok_t                 mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wp_q, rp_q;
	logic [FIFO_AW:0]     count_q;

	// leave space for the two tokens one byte can make
	assign room = count_q <= (FIFO_AW+1)'(FIFO_DEPTH - 2);
	assign nonempty = count_q != '0;
	assign head = mem[rp_q];

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) mem[wp_q] <= push.tok0;
		if (push.cnt == 2'd2) mem[wp_q + 1'b1] <= push.tok1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			count_q <= '0;
		end else begin
			wp_q <= wp_q + FIFO_AW'(push.cnt);
			if (pop) rp_q <= rp_q + 1'b1;
			count_q <= count_q + (FIFO_AW+1)'(push.cnt) - (FIFO_AW+1)'(pop);
		end
	end

endmodule

// File: rtl/core/ctss_out.sv
// Back end: output register that drives the token stream
module ctss_out (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           nonempty,
	input  ctss_pkg::tok_t head,
	output logic           pop,
	output logic           m_axis_tvalid,
	input  logic           m_axis_tready,
	output logic [31:0]    m_axis_tdata,  // token_kind[5:0], token_length[13:6], line_number[29:14]
	output logic           m_axis_tlast
);
	import ctss_pkg::*;

	tok_t tok_q;
	logic valid_q;

	// refill when empty or the held beat is taken
	assign pop = nonempty && (!valid_q || m_axis_tready);
	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata = {2'b00, tok_q.line, tok_q.len, tok_q.kind};
	assign m_axis_tlast = tok_q.last;

	always_ff @(posedge clk) begin
		if (pop) tok_q <= head;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (pop) valid_q <= 1'b1;
		else if (m_axis_tready) valid_q <= 1'b0;
	end

endmodule

// File: rtl/core/c_subset_token_scanner.sv
// Path: a token enters the token queue with the byte that ends it, then the output register.
// Throughput: one byte per cycle; a byte that makes two tokens uses two output beats,
// and input stalls when the four-entry token queue has fewer than two free slots.
// Reset: arst_n clears scanner state (idle, line 1), the queue and the output valid flag.
// Top level of the C subset token scanner
module c_subset_token_scanner #(
	parameter int LINE_COUNT_BITS = 16,
	parameter int LENGTH_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // source_byte[7:0]
	input  logic        s_axis_tuser,   // end_of_input[0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // token_kind[5:0], token_length[13:6], line_number[29:14]
	output logic        m_axis_tlast    // last_of_run
);
	import ctss_pkg::*;

	push_t push;
	tok_t  head;
	logic  room, nonempty, pop;

	assign s_axis_tready = room;

	ctss_scan #(
		.LINE_COUNT_BITS(LINE_COUNT_BITS),
		.LENGTH_BITS(LENGTH_BITS)
	) u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.take(s_axis_tvalid && room),
		.source_byte(s_axis_tdata),
		.end_of_input(s_axis_tuser),
		.push(push)
	);

	ctss_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.room(room),
		.nonempty(nonempty),
		.head(head),
		.pop(pop)
	);

	ctss_out u_out (
		.clk(clk),
		.arst_n(arst_n),
		.nonempty(nonempty),
		.head(head),
		.pop(pop),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

endmodule

// File: rtl/core/ctss_check.sv
// Port-level checker for the token scanner and its bind
`include "c_subset_token_scanner_defines.svh"

module ctss_check (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        m_axis_tlast
);
	import ctss_pkg::*;

	`CTSS_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output beat changed while stalled")
	`CTSS_ASSERT_NOW(a_kind, m_axis_tvalid, m_axis_tdata[5:0] <= K_COMMENT && m_axis_tdata[31:30] == 2'b00, "token kind out of range")
	`CTSS_ASSERT_NOW(a_end, m_axis_tvalid && m_axis_tdata[5:0] == K_END, m_axis_tdata[13:6] == 8'd0 && m_axis_tlast, "end token not empty and last")
	`CTSS_ASSERT_NOW(a_line, m_axis_tvalid, m_axis_tdata[29:14] != 16'd0, "line number is zero")
endmodule

bind c_subset_token_scanner ctss_check u_check (
	.clk(clk),
	.arst_n(arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata),
	.m_axis_tlast(m_axis_tlast)
);

// File: tb/tb_top.sv
// Self-checking testbench for the C subset token scanner
module tb_top;
	import ctss_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_IDLE = 20000;
	localparam int RAND_ITEMS = 60;

	// scanner states of the predictor
	typedef enum logic [3:0] {
		S_IDLE, S_IDENT, S_NUM, S_DOT, S_SLASH, S_LINE, S_BLOCK, S_BSTAR,
		S_PREP, S_CH_OPEN, S_CH_ESC, S_CH_BODY, S_OPER
	} scan_t;
	typedef enum logic [1:0] {NUM_INT, NUM_HEX, NUM_FRAC} numpart_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic m_axis_tlast;

	c_subset_token_scanner u_top (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor state
	scan_t mode;
	numpart_t npart;
	int unsigned tlen;
	int unsigned lineno;
	logic [9:0] kwmask;
	logic [7:0] first_ch;
	tok_t token_q[$];
	tok_t step_toks[$];

	int errors = 0;
	int tokens_seen = 0;
	int bytes_sent = 0;
	int idle_cycles = 0;
	bit hold_rx = 1'b0;

	function automatic bit dig(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction
	function automatic bit alp(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction
	function automatic bit hexd(logic [7:0] c);
		return dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic logic [7:0] kw_char(int i, int unsigned pos);
		string s;
		case (i)
			0: s = "int";
			1: s = "float";
			2: s = "char";
			3: s = "if";
			4: s = "else";
			5: s = "while";
			6: s = "for";
			7: s = "return";
			8: s = "break";
			default: s = "continue";
		endcase
		if (pos >= s.len()) return 8'h00;
		return s[pos];
	endfunction

	function automatic int kw_length(int i);
		int lens[10] = '{3, 5, 4, 2, 4, 5, 3, 6, 5, 8};
		return lens[i];
	endfunction

	task automatic add_token(logic [5:0] k, int unsigned l);
		tok_t t;
		t.kind = k;
		t.len = (l > 255) ? 8'd255 : l[7:0];
		t.line = (lineno > 65535) ? 16'hffff : lineno[15:0];
		t.last = 1'b0;
		step_toks.push_back(t);
	endtask

	task automatic grow_len();
		if (tlen < 255) tlen++;
	endtask

	task automatic count_line();
		if (lineno < 65535) lineno++;
	endtask

	task automatic narrow_keywords(logic [7:0] c);
		for (int i = 0; i < 10; i++)
			if (kwmask[i] && (tlen >= kw_length(i) || kw_char(i, tlen) != c))
				kwmask[i] = 1'b0;
	endtask

	function automatic logic [5:0] ident_or_keyword();
		for (int i = 0; i < 10; i++)
			if (kwmask[i] && kw_length(i) == tlen) return K_KW0 + 6'(i);
		return K_IDENT;
	endfunction

	function automatic logic [5:0] lone_oper(logic [7:0] f);
		if (f == "=") return K_ASSIGN;
		if (f == "<") return K_LT;
		if (f == ">") return K_GT;
		return K_ERR;
	endfunction

	// continue the pending token; return 1 when the byte is consumed
	task automatic continue_token(logic [7:0] c, output bit used);
		logic [5:0] k;
		used = 1'b1;
		case (mode)
			S_IDENT: begin
				if (alp(c) || dig(c) || c == "_") begin
					narrow_keywords(c);
					grow_len();
					return;
				end
				add_token(ident_or_keyword(), tlen);
			end
			S_NUM: begin
				if (npart == NUM_FRAC) begin
					if (dig(c)) begin
						grow_len();
						return;
					end
					if (c == "F" || c == "f") begin
						grow_len();
						add_token(K_FLOAT, tlen);
						mode = S_IDLE;
						return;
					end
					add_token(K_FLOAT, tlen);
				end else begin
					if (npart == NUM_HEX && hexd(c)) begin
						grow_len();
						return;
					end
					if (npart == NUM_INT && dig(c)) begin
						grow_len();
						return;
					end
					if (npart == NUM_INT && (c == "x" || c == "X") && tlen == 1
							&& first_ch == "0") begin
						grow_len();
						npart = NUM_HEX;
						return;
					end
					if (c == ".") begin
						grow_len();
						npart = NUM_FRAC;
						return;
					end
					if (c == "F" || c == "f" || c == "L" || c == "l") begin
						grow_len();
						add_token((c == "F" || c == "f") ? K_FLOAT : K_LONG, tlen);
						mode = S_IDLE;
						return;
					end
					add_token(K_INT, tlen);
				end
			end
			S_DOT: begin
				if (dig(c)) begin
					grow_len();
					mode = S_NUM;
					npart = NUM_FRAC;
					return;
				end
				add_token(K_ERR, tlen);
			end
			S_SLASH: begin
				if (c == "/" || c == "*") begin
					grow_len();
					mode = (c == "/") ? S_LINE : S_BLOCK;
					return;
				end
				add_token(K_SLASH, tlen);
			end
			S_LINE, S_PREP: begin
				if (c != 8'h0a) begin
					grow_len();
					return;
				end
				add_token(mode == S_LINE ? K_COMMENT : K_PREP, tlen);
			end
			S_BLOCK, S_BSTAR: begin
				grow_len();
				if (c == "/" && mode == S_BSTAR) begin
					add_token(K_COMMENT, tlen);
					mode = S_IDLE;
					return;
				end
				if (c == 8'h0a) count_line();
				mode = (c == "*") ? S_BSTAR : S_BLOCK;
				return;
			end
			S_CH_OPEN: begin
				grow_len();
				if (c == "\\") mode = S_CH_ESC;
				else if (c == "'" || c == 8'h0a) begin
					add_token(K_ERR, tlen);
					mode = S_IDLE;
				end else mode = S_CH_BODY;
				return;
			end
			S_CH_ESC: begin
				grow_len();
				if (c == "n" || c == "t" || c == "r" || c == "0") mode = S_CH_BODY;
				else begin
					add_token(K_ERR, tlen);
					mode = S_IDLE;
				end
				return;
			end
			S_CH_BODY: begin
				grow_len();
				add_token(c == "'" ? K_CHAR : K_ERR, tlen);
				mode = S_IDLE;
				return;
			end
			S_OPER: begin
				k = K_ERR;
				if (c == "=") begin
					if (first_ch == "=") k = K_EQ;
					else if (first_ch == "!") k = K_NE;
					else if (first_ch == "<") k = K_LE;
					else if (first_ch == ">") k = K_GE;
				end
				if (first_ch == "&" && c == "&") k = K_AND;
				if (first_ch == "|" && c == "|") k = K_OR;
				if (k != K_ERR) begin
					grow_len();
					add_token(k, tlen);
					mode = S_IDLE;
					return;
				end
				add_token(lone_oper(first_ch), tlen);
			end
			default: ;
		endcase
		mode = S_IDLE;
		used = 1'b0;
	endtask

	task automatic start_token(logic [7:0] c);
		if (c == " " || c == 8'h09 || c == 8'h0d) return;
		if (c == 8'h0a) begin
			count_line();
			return;
		end
		tlen = 1;
		first_ch = c;
		npart = NUM_INT;
		if (alp(c) || c == "_") begin
			kwmask = '1;
			tlen = 0;
			narrow_keywords(c);
			tlen = 1;
			mode = S_IDENT;
			return;
		end
		if (dig(c)) begin
			mode = S_NUM;
			return;
		end
		case (c)
			".": mode = S_DOT;
			"/": mode = S_SLASH;
			"#": mode = S_PREP;
			"'": mode = S_CH_OPEN;
			"=", "!", "<", ">", "&", "|": mode = S_OPER;
			default: add_token(single_kind(c), 1);
		endcase
	endtask

	task automatic flush_pending();
		case (mode)
			S_IDENT: add_token(ident_or_keyword(), tlen);
			S_NUM: add_token(npart == NUM_FRAC ? K_FLOAT : K_INT, tlen);
			S_SLASH: add_token(K_SLASH, tlen);
			S_LINE: add_token(K_COMMENT, tlen);
			S_PREP: add_token(K_PREP, tlen);
			S_OPER: add_token(lone_oper(first_ch), tlen);
			S_IDLE: ;
			default: add_token(K_ERR, tlen);
		endcase
		mode = S_IDLE;
	endtask

	task automatic predict_tokens(logic [7:0] c, logic eof);
		bit used;
		step_toks.delete();
		if (eof) begin
			flush_pending();
			add_token(K_END, 0);
		end else begin
			used = 1'b0;
			if (mode != S_IDLE) continue_token(c, used);
			if (!used) start_token(c);
		end
		if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
		foreach (step_toks[i]) token_q.push_back(step_toks[i]);
	endtask

	// send one byte (or end marker) after a random gap; valid stays up between beats when no gap is drawn
	task automatic send_byte(logic [7:0] c, logic eof = 1'b0);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= c;
		s_axis_tuser <= eof;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_tokens(c, eof);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i]);
	endtask

	// receiver ready: random stalls, or held low during reset and the pressure window
	always @(negedge clk) begin
		if (hold_rx || !arst_n) m_axis_tready <= 1'b0;
		else if ($urandom_range(0, 3) == 0) m_axis_tready <= ($urandom_range(0, 17) == 0);
		else m_axis_tready <= 1'b1;
	end

	// compare each output beat against the oldest predicted token
	always @(posedge clk) begin
		tok_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.kind = m_axis_tdata[5:0];
			got.len = m_axis_tdata[13:6];
			got.line = m_axis_tdata[29:14];
			got.last = m_axis_tlast;
			tokens_seen++;
			if (token_q.size() == 0) begin
				$display("%0t: unexpected token kind %0d len %0d line %0d", $time,
					got.kind, got.len, got.line);
				errors++;
			end else begin
				want = token_q.pop_front();
				if (got != want) begin
					$display("%0t: token mismatch exp kind %0d len %0d line %0d last %0b",
						$time, want.kind, want.len, want.line, want.last);
					$display("%0t:                got kind %0d len %0d line %0d last %0b",
						$time, got.kind, got.len, got.line, got.last);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else if (arst_n) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= MAX_IDLE) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	task automatic test_tokens_directed();
		send_text("int float char if else while for return break continue _x9 ");
		send_text("0 017 0x1fL 12l 1.5 .5 1. 3f 0x1.8F 1.5L . ");
		send_text("+-*/%=== != ! >>=<<= &&& || | ()[]{};,@");
		send_byte(8'h7f);
		send_byte(8'hff);
		send_byte(8'h00);
		send_text("'a' '\\n' '\\t' '\\r' '\\0' '' '\\q' 'ab ''\n// c\n# x\n/* a\n**/");
		send_byte(8'h00, 1'b1);
		send_text("'\n");
		send_text("/* open");
		send_byte(8'h00, 1'b1);
	endtask

	task automatic test_long_tokens();
		send_text("//");
		repeat (260) send_byte("a");
		send_byte(8'h0a);
		send_text("ab");
		repeat (260) send_byte("9");
		send_byte(8'h00, 1'b1);
	endtask

	task automatic test_output_backpressure();
		fork
			begin
				hold_rx = 1'b1;
				repeat (60) @(negedge clk);
				hold_rx = 1'b0;
			end
			send_text("a+b;c(d)[e]{f},g%h*i-j");
		join
	endtask

	function automatic logic [7:0] pick_char();
		string frag = "abceifnortwlsuhkx_019LFfXl.'\\/*#=!<>&|+-%()[]{};, \n\t\r";
		case ($urandom_range(0, 9))
			0: return 8'($urandom_range(0, 255));
			default: return frag[$urandom_range(0, frag.len() - 1)];
		endcase
	endfunction

	task automatic test_random_source();
		string words[] = '{"int ", "float ", "while(", "return ", "continue;", "x1 ",
			"0x3fL ", "1.25f ", ".5 ", "'\\n' ", "'z' ", "a<=b ", "c!=d ", "&& ",
			"/* q*/", "// r\n", "#define\n", "\n", "07 ", "9.e "};
		string w;
		int n;
		n = 0;
		while (n < RAND_ITEMS) begin
			if ($urandom_range(0, 3) != 0) begin
				w = words[$urandom_range(0, words.size() - 1)];
				send_text(w);
				n += w.len();
			end else begin
				send_byte(pick_char());
				n++;
			end
			if ($urandom_range(0, 150) == 0) send_byte(8'($urandom), 1'b1);
		end
		send_byte(8'h00, 1'b1);
	endtask

	initial begin
		mode = S_IDLE;
		npart = NUM_INT;
		tlen = 0;
		lineno = 1;
		kwmask = '1;
		first_ch = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_tokens_directed();
		test_long_tokens();
		test_output_backpressure();
		test_random_source();
		s_axis_tvalid <= 1'b0;
		while (token_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("Sent %0d source bytes; checked %0d tokens incl. keywords, numbers,",
			bytes_sent, tokens_seen);
		$display("chars, comments, operators, saturation and output stalls.");
		if (errors == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end
endmodule
